// File: hdl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg: shared constants and types for the bit plane transpose
// element and plane widths, group size, register reset, handoff struct
// ----------------------------------------------------------------------------
package bpt_pkg;

   localparam int GROUP_SIZE         = 64;
   localparam int GROUP_W            = $clog2(GROUP_SIZE);
   localparam int MAX_PLANES_DEFAULT = 16;
   localparam int ELEM_W             = 16;
   localparam int CFG_W              = 5;
   localparam int PLANE_BIT_W        = 4;

   localparam logic [CFG_W-1:0] QUERY_BITS_RESET = CFG_W'(4);

   // group handoff from accumulator to emitter
   typedef struct packed {
      logic valid;
      logic eoq;
   } bpt_close_type;

endpackage

// File: hdl/bpt_req_if.sv
// ----------------------------------------------------------------------------
// bpt_req_if: element input channel
// valid/ready handshake carrying one query element per beat
// ----------------------------------------------------------------------------
interface bpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpt_pkg::ELEM_W-1:0]    element_value;
   logic                          end_of_query;

   modport source (output valid, output element_value, output end_of_query, input ready);
   modport sink   (input valid, input element_value, input end_of_query, output ready);
endinterface

// File: hdl/bpt_rsp_if.sv
// ----------------------------------------------------------------------------
// bpt_rsp_if: plane output channel
// valid/ready handshake carrying one bit plane word per beat
// ----------------------------------------------------------------------------
interface bpt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bpt_pkg::GROUP_SIZE-1:0]     plane_word;
   logic [bpt_pkg::PLANE_BIT_W-1:0]    plane_bit;
   logic                               last_plane;
   logic                               query_done;

   modport source (output valid, output plane_word, output plane_bit,
                   output last_plane, output query_done, input ready);
   modport sink   (input valid, input plane_word, input plane_bit,
                   input last_plane, input query_done, output ready);
endinterface

// File: hdl/bit_plane_transpose_64.sv
// ----------------------------------------------------------------------------
// bit_plane_transpose_64: query element to bit plane transpose
// collects 64-element groups and emits one 64-bit word per significant bit
// ----------------------------------------------------------------------------
// Elements enter on req_beat one per beat, and one beat is taken every cycle
// while the plane buffer can hold the next group. Each element's bits are
// scattered into the plane words as it arrives (element 0 of a group at bit
// 63). The 64th element, or one marked end_of_query, closes the group: its
// planes move to a buffer and leave on rsp_beat one per cycle while it is
// ready, plane 0 first, query_bits planes per group (0 counts as 1, values
// above MAX_PLANES count as MAX_PLANES). A closing element waits only if the
// previous group still has planes in the buffer, so with a ready receiver a
// full group of 64 streams with no stall; short groups cut by end_of_query
// can stall the input, limited by the single plane output port. A closing
// element reaches its first plane via the input register, group buffer and
// output register. query_bits takes csr_wr_data on csr_wr_en and resets to 4.
// ----------------------------------------------------------------------------
module bit_plane_transpose_64 #(
   parameter int MAX_PLANES = bpt_pkg::MAX_PLANES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   bpt_req_if.sink                    req_beat,
   bpt_rsp_if.source                  rsp_beat,
   input  logic                       csr_wr_en,
   input  logic [bpt_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int QB_W = $clog2(MAX_PLANES + 1);

   logic [bpt_pkg::CFG_W-1:0]                      query_bits_ff;
   logic [QB_W-1:0]                                planes;
   logic                                           hand_free;
   bpt_pkg::bpt_close_type                         close;
   logic [MAX_PLANES-1:0][bpt_pkg::GROUP_SIZE-1:0] close_planes;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         query_bits_ff <= bpt_pkg::QUERY_BITS_RESET;
      end else if (csr_wr_en) begin
         query_bits_ff <= csr_wr_data;
      end
   end

   // clamp the plane count into 1..MAX_PLANES
   always_comb begin
      if (query_bits_ff == '0) begin
         planes = QB_W'(1);
      end else if (32'(query_bits_ff) > 32'(MAX_PLANES)) begin
         planes = QB_W'(MAX_PLANES);
      end else begin
         planes = QB_W'(query_bits_ff);
      end
   end

   // element input register and plane accumulation
   bpt_accum #(
      .MAX_PLANES (MAX_PLANES)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .req_beat     (req_beat),
      .hand_free    (hand_free),
      .close        (close),
      .close_planes (close_planes)
   );

   // closed group buffer and plane output register
   bpt_emitter #(
      .MAX_PLANES (MAX_PLANES),
      .QB_W       (QB_W)
   ) u_emitter (
      .clock        (clock),
      .reset        (reset),
      .close        (close),
      .close_planes (close_planes),
      .planes       (planes),
      .hand_free    (hand_free),
      .rsp_beat     (rsp_beat)
   );

endmodule

// File: hdl/bpt_accum.sv
// ----------------------------------------------------------------------------
// bpt_accum: input register and plane accumulator
// scatters each element's bits into the plane words, hands off closed groups
// ----------------------------------------------------------------------------
module bpt_accum #(
   parameter int MAX_PLANES = bpt_pkg::MAX_PLANES_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   bpt_req_if.sink                                      req_beat,
   input  logic                                         hand_free,
   output bpt_pkg::bpt_close_type                       close,
   output logic [MAX_PLANES-1:0][bpt_pkg::GROUP_SIZE-1:0] close_planes
);

   logic                                         in_valid_ff;
   logic [bpt_pkg::ELEM_W-1:0]                   in_value_ff;
   logic                                         in_eoq_ff;
   logic [bpt_pkg::GROUP_W-1:0]                  count_ff, count_in;
   logic [MAX_PLANES-1:0][bpt_pkg::GROUP_SIZE-1:0] acc_ff, acc_in;
   logic [bpt_pkg::GROUP_W-1:0]                  pos;
   logic                                         closes;
   logic                                         advance;

   assign pos     = bpt_pkg::GROUP_W'(bpt_pkg::GROUP_SIZE - 1) - count_ff;
   assign closes  = in_eoq_ff || (count_ff == bpt_pkg::GROUP_W'(bpt_pkg::GROUP_SIZE - 1));
   // a closing beat waits until the emitter can take the group
   assign advance = in_valid_ff && (!closes || hand_free);
   assign req_beat.ready = !in_valid_ff || advance;

   always_comb begin
      for (int p = 0; p < MAX_PLANES; p++) begin
         close_planes[p] = acc_ff[p]
            | (bpt_pkg::GROUP_SIZE'(in_value_ff[p]) << pos);
      end
      close.valid = advance && closes;
      close.eoq   = in_eoq_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      if (advance) begin
         if (closes) begin
            acc_in   = '0;
            count_in = '0;
         end else begin
            acc_in   = close_planes;
            count_in = count_ff + bpt_pkg::GROUP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
         acc_ff      <= '0;
      end else begin
         count_ff <= count_in;
         acc_ff   <= acc_in;
         if (req_beat.ready) begin
            in_valid_ff <= req_beat.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat.ready && req_beat.valid) begin
         in_value_ff <= req_beat.element_value;
         in_eoq_ff   <= req_beat.end_of_query;
      end
   end

endmodule

// File: hdl/bpt_emitter.sv
// ----------------------------------------------------------------------------
// bpt_emitter: group buffer and plane output register
// holds one closed group and sends its planes one per beat, plane 0 first
// ----------------------------------------------------------------------------
module bpt_emitter #(
   parameter int MAX_PLANES = bpt_pkg::MAX_PLANES_DEFAULT,
   parameter int QB_W       = $clog2(MAX_PLANES + 1)
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bpt_pkg::bpt_close_type                       close,
   input  logic [MAX_PLANES-1:0][bpt_pkg::GROUP_SIZE-1:0] close_planes,
   input  logic [QB_W-1:0]                              planes,
   output logic                                         hand_free,
   bpt_rsp_if.source                                    rsp_beat
);

   localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   logic [MAX_PLANES-1:0][bpt_pkg::GROUP_SIZE-1:0] grp_ff;
   logic                                         busy_ff;
   logic [IDX_W-1:0]                             idx_ff;
   logic [QB_W-1:0]                              qb_ff;
   logic                                         eoq_ff;
   logic                                         out_valid_ff;
   logic [bpt_pkg::GROUP_SIZE-1:0]               word_ff;
   logic [bpt_pkg::PLANE_BIT_W-1:0]              bit_ff;
   logic                                         last_ff;
   logic                                         done_ff;
   logic                                         out_load;
   logic                                         is_last;

   assign out_load  = busy_ff && (!out_valid_ff || rsp_beat.ready);
   assign is_last   = (QB_W'(idx_ff) + QB_W'(1)) == qb_ff;
   assign hand_free = !busy_ff || (out_load && is_last);

   assign rsp_beat.valid      = out_valid_ff;
   assign rsp_beat.plane_word = word_ff;
   assign rsp_beat.plane_bit  = bit_ff;
   assign rsp_beat.last_plane = last_ff;
   assign rsp_beat.query_done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (close.valid) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (out_load) begin
            if (is_last) begin
               busy_ff <= 1'b0;
            end
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_beat.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (close.valid) begin
         grp_ff <= close_planes;
         qb_ff  <= planes;
         eoq_ff <= close.eoq;
      end
      if (out_load) begin
         word_ff <= grp_ff[idx_ff];
         bit_ff  <= bpt_pkg::PLANE_BIT_W'(idx_ff);
         last_ff <= is_last;
         done_ff <= is_last && eoq_ff;
      end
   end

endmodule

// File: bench/bit_plane_transpose_64_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_plane_transpose_64_tb: self-checking bench for the bit plane transpose
// streams query elements in, predicts every plane word with a local copy of
// the plane store, and checks each plane beat field by field in arrival order
// ----------------------------------------------------------------------------
module bit_plane_transpose_64_tb;

   localparam int GROUP_SIZE  = bpt_pkg::GROUP_SIZE;
   localparam int PLANE_BIT_W = bpt_pkg::PLANE_BIT_W;
   localparam int CFG_W       = bpt_pkg::CFG_W;
   localparam int ELEM_W      = bpt_pkg::ELEM_W;

   // one expected plane beat
   typedef struct packed {
      logic [GROUP_SIZE-1:0]  word;
      logic [PLANE_BIT_W-1:0] bit_idx;
      logic                   last;
      logic                   done;
   } plane_beat_type;

   // directed row: optional query_bits write, one element, and for rows whose
   // planes are obvious, the word every emitted plane must carry
   typedef struct packed {
      bit                    wr_bits;
      logic [CFG_W-1:0]      bits;
      logic [ELEM_W-1:0]     value;
      bit                    eoq;
      bit                    typed;
      logic [GROUP_SIZE-1:0] word;
   } stim_row_type;

   localparam int NUM_PLANES   = bpt_pkg::MAX_PLANES_DEFAULT;
   localparam int TARGET_ITEMS = 310;
   localparam int SETTLE_CYCLES = 8;     // wait after the last due plane arrives
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam logic [GROUP_SIZE-1:0] TOP_BIT = {1'b1, {(GROUP_SIZE-1){1'b0}}};

   localparam stim_row_type DIRECTED_ROWS [12] = '{
      // reset setting of 4 planes, upper value bits dropped
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, TOP_BIT},
      // widest setting, all 16 planes carry element 0
      '{1'b1, 5'd16, 16'hFFFF, 1'b1, 1'b1, TOP_BIT},
      // zero setting counts as one plane
      '{1'b1, 5'd0,  16'h0001, 1'b1, 1'b1, TOP_BIT},
      // largest register value clamps to 16 planes
      '{1'b1, 5'd31, 16'h0000, 1'b1, 1'b1, '0},
      // one plane, top value bit must not show up
      '{1'b1, 5'd1,  16'h8000, 1'b1, 1'b1, '0},
      // short three element group
      '{1'b1, 5'd16, 16'hA5A5, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h5A5A, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b0, '0},
      // setting changed in the middle of a group
      '{1'b1, 5'd2,  16'h00FF, 1'b0, 1'b0, '0},
      '{1'b1, 5'd8,  16'hFF00, 1'b1, 1'b0, '0},
      // just above range clamps to 16
      '{1'b1, 5'd17, 16'h8001, 1'b1, 1'b0, '0},
      // all significant bits set
      '{1'b1, 5'd15, 16'h7FFF, 1'b1, 1'b1, TOP_BIT}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [CFG_W-1:0]   csr_wr_data;

   bpt_req_if req_chan ();
   bpt_rsp_if rsp_chan ();

   bit_plane_transpose_64 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_chan),
      .rsp_beat    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: plane store, slot of the next element, register copy
   logic [GROUP_SIZE-1:0] stored_planes [NUM_PLANES];
   int                    group_slot;
   logic [CFG_W-1:0]      bits_setting;
   plane_beat_type        planes_due [$];

   int  error_count;
   int  elements_sent;
   bit  calm;          // no idling on either side while set
   bit  hold_rsp;      // asks the receiver for one long hold-off

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   // register value 0 means one plane, anything above 16 means 16
   function automatic int planes_active();
      if (bits_setting == 0)
         return 1;
      if (bits_setting > NUM_PLANES)
         return NUM_PLANES;
      return int'(bits_setting);
   endfunction

   // scatter one accepted element and queue the planes a closing element causes
   function automatic void predict_planes(input logic [ELEM_W-1:0] value, input bit eoq,
                                          input bit typed,
                                          input logic [GROUP_SIZE-1:0] typed_word);
      int             pos;
      int             n;
      plane_beat_type beat;
      pos = GROUP_SIZE - 1 - group_slot;
      for (int p = 0; p < NUM_PLANES; p++)
         if (value[p])
            stored_planes[p][pos] = 1'b1;
      if (group_slot != GROUP_SIZE - 1 && !eoq) begin
         group_slot++;
         return;
      end
      n = planes_active();
      for (int p = 0; p < n; p++) begin
         beat.word    = typed ? typed_word : stored_planes[p];
         beat.bit_idx = PLANE_BIT_W'(p);
         beat.last    = (p == n - 1);
         beat.done    = (p == n - 1) && eoq;
         planes_due.push_back(beat);
      end
      for (int p = 0; p < NUM_PLANES; p++)
         stored_planes[p] = '0;
      group_slot = 0;
   endfunction

   // offer one element after a random gap, predict once it is taken
   task automatic send_element(input logic [ELEM_W-1:0] value, input bit eoq,
                               input bit typed, input logic [GROUP_SIZE-1:0] typed_word);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.element_value <= value;
      req_chan.end_of_query  <= eoq;
      do @(posedge clock); while (!req_chan.ready);
      elements_sent++;
      predict_planes(value, eoq, typed, typed_word);
   endtask

   // stop offering, let every due plane arrive, then let the pipeline settle
   task automatic wait_planes_drained();
      req_chan.valid <= 1'b0;
      while (planes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only happen once every due plane has arrived
   task automatic write_query_bits(input logic [CFG_W-1:0] value);
      wait_planes_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      bits_setting  = value;
   endtask

   // mostly legal settings, now and then the clamped corners
   function automatic logic [CFG_W-1:0] pick_query_bits();
      case ($urandom_range(0, 9))
         0: return 5'd0;
         1: return 5'd31;
         2: return CFG_W'($urandom_range(17, 30));
         3: return 5'd16;
         4: return 5'd1;
         default: return CFG_W'($urandom_range(1, 16));
      endcase
   endfunction

   // one query of len elements, end_of_query on the last one
   task automatic run_query(input int len, input bit may_cut);
      int                cut;
      int                style;
      logic [ELEM_W-1:0] value;
      logic [ELEM_W-1:0] mask;
      cut   = (may_cut && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
      style = $urandom_range(0, 7);
      for (int k = 0; k < len; k++) begin
         // setting change somewhere inside the query, maybe mid-group
         if (k == cut)
            write_query_bits(pick_query_bits());
         value = ELEM_W'($urandom_range(0, 65535));
         if (style == 0) begin
            // only significant bits populated
            mask  = ELEM_W'((32'h1 << planes_active()) - 1);
            value = value & mask;
         end else if (style == 1) begin
            value = $urandom_range(0, 1) ? '1 : '0;
         end
         send_element(value, k == len - 1, 1'b0, '0);
      end
   endtask

   // receiver: random stall per beat, one long hold-off on request
   initial begin : receiver
      int stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid && !hold_rsp);
      end
   end

   // compare each accepted plane beat with the oldest one due
   always @(posedge clock) begin : check_planes
      plane_beat_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (planes_due.size() == 0) begin
            report_mismatch("plane beat with none due", rsp_chan.plane_word, '0);
         end else begin
            due = planes_due.pop_front();
            if (rsp_chan.plane_word !== due.word)
               report_mismatch("plane_word", rsp_chan.plane_word, due.word);
            if (rsp_chan.plane_bit !== due.bit_idx)
               report_mismatch("plane_bit", 64'(rsp_chan.plane_bit), 64'(due.bit_idx));
            if (rsp_chan.last_plane !== due.last)
               report_mismatch("last_plane", 64'(rsp_chan.last_plane), 64'(due.last));
            if (rsp_chan.query_done !== due.done)
               report_mismatch("query_done", 64'(rsp_chan.query_done), 64'(due.done));
         end
      end
   end

   // hard stop, far above the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int len;
      // every input known from time zero
      req_chan.valid         = 1'b0;
      req_chan.element_value = '0;
      req_chan.end_of_query  = 1'b0;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      error_count            = 0;
      elements_sent          = 0;
      calm                   = 1'b0;
      hold_rsp               = 1'b0;
      group_slot             = 0;
      bits_setting           = bpt_pkg::QUERY_BITS_RESET;
      for (int p = 0; p < NUM_PLANES; p++)
         stored_planes[p] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: corners of the setting and of the element bits
      for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
         if (DIRECTED_ROWS[r].wr_bits)
            write_query_bits(DIRECTED_ROWS[r].bits);
         send_element(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].eoq,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].word);
      end

      // back-pressure: receiver holds off while full groups keep coming,
      // so the plane buffer fills and the element input has to stall
      write_query_bits(5'd16);
      calm     = 1'b1;
      hold_rsp = 1'b1;
      run_query(150, 1'b0);
      calm = 1'b0;
      wait_planes_drained();

      // random queries, a fresh setting now and then
      while (elements_sent < TARGET_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0)
            write_query_bits(pick_query_bits());
         case ($urandom_range(0, 9)) inside
            0: len = 1;
            1: len = GROUP_SIZE;
            2: len = 2 * GROUP_SIZE;
            [3:5]: len = $urandom_range(2, GROUP_SIZE - 1);
            default: len = $urandom_range(GROUP_SIZE + 1, 140);
         endcase
         // keep the element total close to the target
         if (len > TARGET_ITEMS - elements_sent)
            len = TARGET_ITEMS - elements_sent;
         run_query(len, 1'b1);
      end

      // drain, then watch a little longer for stray beats
      calm = 1'b0;
      wait_planes_drained();
      repeat (20) @(posedge clock);
      if (planes_due.size() != 0)
         report_mismatch("planes never delivered", 64'(planes_due.size()), '0);

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
